[rtl/core/rth_pkg.sv]
// rth_pkg: shared constants and types for the rgb to hsv converter
`default_nettype none

package rth_pkg;

  // result field widths
  localparam int HUE_W = 16;
  localparam int SAT_W = 16;
  localparam int VAL_W = 8;

  // saturation full scale is 2^SAT_SHIFT - 1
  localparam int SAT_SHIFT = 16;

  // quotient bits resolved per divider stage
  localparam int BPS = 2;

  // front end register stages
  localparam int FRONT_STAGES = 2;

  // hue sector offsets
  localparam int OFS_GREEN_SHIFT = 1;
  localparam int OFS_BLUE_SHIFT  = 2;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

endpackage

`default_nettype wire

[rtl/core/rth_pix_if.sv]
// rth_pix_if: input pixel channel with valid/ready handshake
`default_nettype none

interface rth_pix_if #(
  parameter int CHANNEL_BITS = 8
) ();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

[rtl/core/rth_hsv_if.sv]
// rth_hsv_if: result channel carrying hue, saturation and brightness
`default_nettype none

interface rth_hsv_if ();
  import rth_pkg::*;

  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [VAL_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/rgb_to_hsv_top.sv]
// rgb_to_hsv_top: pipelined rgb to hsv pixel converter
// the front end stages are followed by the divider stages
// throughput: one item per cycle while the output is not stalled; each divider stage resolves two quotient bits
// saturation and hue dividers run side by side with equal depth
// a stalled output holds its item while empty stages upstream keep filling
// reset (synchronous, active low) clears the stage valid bits only
`default_nettype none

module rgb_to_hsv_top #(
  parameter int CHANNEL_BITS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  rth_pix_if.sink     in_pix,
  rth_hsv_if.source   out_hsv
);
  import rth_pkg::*;

  localparam int CB  = CHANNEL_BITS;
  localparam int DVW = CB + 3;
  localparam int QB  = (FRACTION_BITS > SAT_SHIFT) ? FRACTION_BITS : SAT_SHIFT;
  localparam int ND  = (QB + BPS - 1) / BPS;
  localparam int NS  = FRONT_STAGES + ND;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  // stall chain: a stage moves when empty or when the next one moves
  always_comb begin
    en[NS] = out_hsv.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_pix.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_pix.ready = en[0];

  logic [CB-1:0]  f_mx;
  logic           f_grey;
  logic [DVW-1:0] h_rem0, h_den, s_rem0, s_den;
  logic [QB-1:0]  h_work0, s_work0, h_quo, s_quo;

  rth_front #(
    .CB (CB),
    .FB (FRACTION_BITS),
    .Q  (QB)
  ) u_front (
    .clk       (clk),
    .en        (en[FRONT_STAGES-1:0]),
    .red       (in_pix.red),
    .green     (in_pix.green),
    .blue      (in_pix.blue),
    .mx        (f_mx),
    .grey      (f_grey),
    .hue_rem0  (h_rem0),
    .hue_work0 (h_work0),
    .hue_den   (h_den),
    .sat_rem0  (s_rem0),
    .sat_work0 (s_work0),
    .sat_den   (s_den)
  );

  rth_div #(
    .DVW (DVW),
    .Q   (QB)
  ) u_hue_div (
    .clk   (clk),
    .en    (en[NS-1:FRONT_STAGES]),
    .rem0  (h_rem0),
    .work0 (h_work0),
    .den   (h_den),
    .quo   (h_quo)
  );

  rth_div #(
    .DVW (DVW),
    .Q   (QB)
  ) u_sat_div (
    .clk   (clk),
    .en    (en[NS-1:FRONT_STAGES]),
    .rem0  (s_rem0),
    .work0 (s_work0),
    .den   (s_den),
    .quo   (s_quo)
  );

  // brightness and grey flag ride alongside the dividers
  logic [CB-1:0] mx_r  [ND];
  logic          grey_r[ND];

  always_ff @(posedge clk) begin
    if (en[FRONT_STAGES]) begin
      mx_r[0]   <= f_mx;
      grey_r[0] <= f_grey;
    end
    for (int k = 1; k < ND; k++) begin
      if (en[FRONT_STAGES+k]) begin
        mx_r[k]   <= mx_r[k-1];
        grey_r[k] <= grey_r[k-1];
      end
    end
  end

  assign out_hsv.valid      = v_r[NS-1];
  assign out_hsv.hue        = HUE_W'(h_quo);
  assign out_hsv.saturation = s_quo[SAT_W-1:0];
  assign out_hsv.brightness = VAL_W'(mx_r[ND-1]);

  // checks
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.valid && in_pix.ready |=> v_r[0])
    else $error("accepted item did not enter the first stage");

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !en[0] |=> v_r[0])
    else $error("stalled front stage dropped its item");

  a_grey_sat: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] |-> ((s_quo == '0) == grey_r[ND-1]))
    else $error("saturation zero disagrees with grey flag");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] && (mx_r[ND-1] == '0) |-> (h_quo == '0) && (s_quo == '0))
    else $error("black pixel gave nonzero hue or saturation");

endmodule

`default_nettype wire

[rtl/core/rth_front.sv]
// rth_front: max/min search, sector select and divider operand setup (two stages)
`default_nettype none

module rth_front #(
  parameter int  CB = 8,
  parameter int  FB = 16,
  parameter int  Q  = 16,
  localparam int DVW = CB + 3
) (
  input  logic                             clk,
  input  logic [rth_pkg::FRONT_STAGES-1:0] en,
  input  logic [CB-1:0]                    red,
  input  logic [CB-1:0]                    green,
  input  logic [CB-1:0]                    blue,
  output logic [CB-1:0]                    mx,
  output logic                             grey,
  output logic [DVW-1:0]                   hue_rem0,
  output logic [Q-1:0]                     hue_work0,
  output logic [DVW-1:0]                   hue_den,
  output logic [DVW-1:0]                   sat_rem0,
  output logic [Q-1:0]                     sat_work0,
  output logic [DVW-1:0]                   sat_den
);
  import rth_pkg::*;

  localparam int NW = CB + 4;
  localparam int FW = DVW + Q;

  // stage 1 registers
  logic [CB-1:0] r1_r, g1_r, b1_r, mx1_r, mn1_r;
  sector_t       sel1_r;

  // stage 2 registers
  logic [CB-1:0]  mx2_r;
  logic           grey2_r;
  logic [DVW-1:0] hrem_r, hden_r, srem_r, sden_r;
  logic [Q-1:0]   hwork_r, swork_r;

  // stage 1 logic
  sector_t       sel_nxt;
  logic [CB-1:0] mx_nxt, mn_nxt;

  always_comb begin
    if (red >= green && red >= blue) begin
      sel_nxt = SEC_RED;
      mx_nxt  = red;
    end else if (green >= blue) begin
      sel_nxt = SEC_GREEN;
      mx_nxt  = green;
    end else begin
      sel_nxt = SEC_BLUE;
      mx_nxt  = blue;
    end
    mn_nxt = red;
    if (green < mn_nxt) mn_nxt = green;
    if (blue < mn_nxt) mn_nxt = blue;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r1_r   <= red;
      g1_r   <= green;
      b1_r   <= blue;
      mx1_r  <= mx_nxt;
      mn1_r  <= mn_nxt;
      sel1_r <= sel_nxt;
    end
  end

  // stage 2 logic
  logic [CB-1:0]        delta;
  logic [DVW-1:0]       d_ext, six;
  logic signed [NW-1:0] rs, gs, bs, ofs, numer;
  logic [DVW-1:0]       numer_u;
  logic [FW-1:0]        hfull, sfull;
  logic                 grey_nxt;

  always_comb begin
    delta    = mx1_r - mn1_r;
    grey_nxt = (delta == '0);
    d_ext    = DVW'(delta);
    six      = (d_ext << 2) + (d_ext << 1);
    rs       = signed'(NW'(r1_r));
    gs       = signed'(NW'(g1_r));
    bs       = signed'(NW'(b1_r));
    case (sel1_r)
      SEC_RED: begin
        ofs   = '0;
        numer = ofs + (gs - bs);
      end
      SEC_GREEN: begin
        ofs   = signed'(NW'(delta) << OFS_GREEN_SHIFT);
        numer = ofs + (bs - rs);
      end
      SEC_BLUE: begin
        ofs   = signed'(NW'(delta) << OFS_BLUE_SHIFT);
        numer = ofs + (rs - gs);
      end
      default: begin
        ofs   = '0;
        numer = '0;
      end
    endcase
    // wrap into one turn
    if (numer[NW-1]) numer = numer + signed'(NW'(six));
    numer_u = numer[DVW-1:0];
    hfull   = grey_nxt ? '0 : (FW'(numer_u) << FB);
    sfull   = (FW'(delta) << SAT_SHIFT) - FW'(delta);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mx2_r   <= mx1_r;
      grey2_r <= grey_nxt;
      hrem_r  <= hfull[FW-1:Q];
      hwork_r <= hfull[Q-1:0];
      hden_r  <= grey_nxt ? DVW'(1) : six;
      srem_r  <= sfull[FW-1:Q];
      swork_r <= sfull[Q-1:0];
      sden_r  <= grey_nxt ? DVW'(1) : DVW'(mx1_r);
    end
  end

  assign mx        = mx2_r;
  assign grey      = grey2_r;
  assign hue_rem0  = hrem_r;
  assign hue_work0 = hwork_r;
  assign hue_den   = hden_r;
  assign sat_rem0  = srem_r;
  assign sat_work0 = swork_r;
  assign sat_den   = sden_r;

endmodule

`default_nettype wire

[rtl/core/rth_div.sv]
// rth_div: pipelined restoring divider, BPS quotient bits per stage
`default_nettype none

module rth_div #(
  parameter int  DVW = 11,
  parameter int  Q   = 16,
  localparam int NST = (Q + rth_pkg::BPS - 1) / rth_pkg::BPS
) (
  input  logic           clk,
  input  logic [NST-1:0] en,
  input  logic [DVW-1:0] rem0,
  input  logic [Q-1:0]   work0,
  input  logic [DVW-1:0] den,
  output logic [Q-1:0]   quo
);
  import rth_pkg::*;

  logic [DVW-1:0] rem_r [NST-1];
  logic [DVW-1:0] den_r [NST-1];
  logic [Q-1:0]   work_r[NST];

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [DVW-1:0] rem_in, den_in, rem_nxt;
    logic [Q-1:0]   work_in, work_nxt;

    if (s == 0) begin : g_first
      assign rem_in  = rem0;
      assign work_in = work0;
      assign den_in  = den;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign work_in = work_r[s-1];
      assign den_in  = den_r[s-1];
    end

    always_comb begin
      logic [DVW:0] sh;
      sh       = '0;
      rem_nxt  = rem_in;
      work_nxt = work_in;
      for (int t = 0; t < BPS; t++) begin
        if (s * BPS + t < Q) begin
          sh = {rem_nxt, work_nxt[Q-1]};
          if (sh >= {1'b0, den_in}) begin
            rem_nxt  = DVW'(sh - {1'b0, den_in});
            work_nxt = {work_nxt[Q-2:0], 1'b1};
          end else begin
            rem_nxt  = sh[DVW-1:0];
            work_nxt = {work_nxt[Q-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        work_r[s] <= work_nxt;
      end
    end

    if (s < NST - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[s]) begin
          rem_r[s] <= rem_nxt;
          den_r[s] <= den_in;
        end
      end
    end
  end

  assign quo = work_r[NST-1];

endmodule

`default_nettype wire

[bench/rgb_to_hsv_top_tb.sv]
// rgb_to_hsv_top_tb: self-checking testbench for the pipelined rgb to hsv pixel converter
`timescale 1ns / 100ps

module rgb_to_hsv_top_tb;
  import rth_pkg::*;

  localparam int CHANNEL_BITS  = 8;
  localparam int FRACTION_BITS = 16;
  localparam int LATENCY       = 10;
  localparam int HOLD_CYCLES   = 80;
  localparam int STALL_LIMIT   = 2000;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [VAL_W-1:0] brightness;
  } hsv_t;

  logic clk = 1'b0;
  logic rst_n;

  rth_pix_if #(.CHANNEL_BITS(CHANNEL_BITS)) pix_ch ();
  rth_hsv_if hsv_ch ();

  rgb_to_hsv_top #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix_ch),
    .out_hsv(hsv_ch)
  );

  always #2 clk = ~clk;

  pixel_t pending_pixels[$];
  hsv_t   hsv_due_q[$];

  int src_idle_pct = 30;
  int snk_idle_pct = 30;
  int hold_req_cnt = 0;
  int hold_done_cnt = 0;
  int hold_left = 0;
  int err_cnt = 0;
  int pixels_sent = 0;
  int results_checked = 0;
  int grey_cnt = 0;
  int wrap_cnt = 0;
  int stall_cycles = 0;

  function automatic hsv_t rgb_to_hsv_calc(pixel_t p);
    int r, g, b, top, bottom, spread, numer, turn;
    sector_t sector;
    hsv_t res;
    r = int'(p.red);
    g = int'(p.green);
    b = int'(p.blue);
    top = r;
    sector = SEC_RED;
    if (g > top) begin
      top = g;
      sector = SEC_GREEN;
    end
    if (b > top) begin
      top = b;
      sector = SEC_BLUE;
    end
    bottom = r;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    spread = top - bottom;
    res = '0;
    res.brightness = VAL_W'(top);
    if (spread != 0) begin
      res.saturation = SAT_W'((64'(spread) * ((64'd1 << SAT_SHIFT) - 64'd1)) / 64'(top));
      case (sector)
        SEC_RED:   numer = g - b;
        SEC_GREEN: numer = (spread << OFS_GREEN_SHIFT) + b - r;
        default:   numer = (spread << OFS_BLUE_SHIFT) + r - g;
      endcase
      turn = 6 * spread;
      if (numer < 0) numer += turn;
      if (numer >= turn) numer -= turn;
      res.hue = HUE_W'((64'(numer) << FRACTION_BITS) / 64'(turn));
    end
    return res;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int pick;
    logic [CHANNEL_BITS-1:0] level;
    pick = $urandom_range(99);
    p.red = CHANNEL_BITS'($urandom);
    p.green = CHANNEL_BITS'($urandom);
    p.blue = CHANNEL_BITS'($urandom);
    level = CHANNEL_BITS'($urandom);
    if (pick < 10) begin
      p = '{level, level, level};
    end else if (pick < 22) begin
      case ($urandom_range(2))
        0: p.green = p.red;
        1: p.blue = p.red;
        default: p.blue = p.green;
      endcase
    end else if (pick < 32) begin
      p = '{CHANNEL_BITS'($urandom_range(7)), CHANNEL_BITS'($urandom_range(7)),
            CHANNEL_BITS'($urandom_range(7))};
    end else if (pick < 42) begin
      p = '{CHANNEL_BITS'($urandom_range(255, 248)), CHANNEL_BITS'($urandom_range(255, 248)),
            CHANNEL_BITS'($urandom_range(255, 248))};
    end
    return p;
  endfunction

  task automatic add_pixel(int r, int g, int b);
    pending_pixels.push_back('{CHANNEL_BITS'(r), CHANNEL_BITS'(g), CHANNEL_BITS'(b)});
  endtask

  task automatic add_random(int count);
    repeat (count) pending_pixels.push_back(rand_pixel());
  endtask

  task automatic wait_sent();
    while (pending_pixels.size() != 0 || pix_ch.valid) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || pix_ch.valid || hsv_due_q.size() != 0)
      @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    hsv_t due;
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        due = rgb_to_hsv_calc('{pix_ch.red, pix_ch.green, pix_ch.blue});
        if (due.saturation == '0) grey_cnt++;
        if (pix_ch.red >= pix_ch.green && pix_ch.red >= pix_ch.blue &&
            pix_ch.green < pix_ch.blue) wrap_cnt++;
        hsv_due_q.push_back(due);
        pixels_sent++;
      end
      if (!pix_ch.valid || pix_ch.ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          pixel_t nxt;
          nxt = pending_pixels.pop_front();
          pix_ch.valid <= 1'b1;
          pix_ch.red   <= nxt.red;
          pix_ch.green <= nxt.green;
          pix_ch.blue  <= nxt.blue;
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    hsv_t due;
    if (!rst_n) begin
      hsv_ch.ready <= 1'b0;
    end else begin
      if (hsv_ch.valid && hsv_ch.ready) begin
        if (hsv_due_q.size() == 0) begin
          $error("result with no pixel pending: hue %0d saturation %0d brightness %0d",
                 hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness);
          err_cnt++;
        end else begin
          due = hsv_due_q.pop_front();
          results_checked++;
          if (hsv_ch.hue !== due.hue) begin
            $error("hue: expected %0d, got %0d", due.hue, hsv_ch.hue);
            err_cnt++;
          end
          if (hsv_ch.saturation !== due.saturation) begin
            $error("saturation: expected %0d, got %0d", due.saturation, hsv_ch.saturation);
            err_cnt++;
          end
          if (hsv_ch.brightness !== due.brightness) begin
            $error("brightness: expected %0d, got %0d", due.brightness, hsv_ch.brightness);
            err_cnt++;
          end
        end
      end
      if (hold_done_cnt != hold_req_cnt) begin
        hold_done_cnt = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        hsv_ch.ready <= 1'b0;
      end else begin
        hsv_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((pix_ch.valid && pix_ch.ready) || (hsv_ch.valid && hsv_ch.ready)) begin
      stall_cycles = 0;
    end else if (rst_n && (pending_pixels.size() != 0 || hsv_due_q.size() != 0 ||
                           pix_ch.valid)) begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without an item moving", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    pix_ch.valid = 1'b0;
    pix_ch.red = '0;
    pix_ch.green = '0;
    pix_ch.blue = '0;
    hsv_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // grey and black, primaries, ties, wraparound near a full turn
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(128, 128, 128);
    add_pixel(1, 1, 1);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(255, 0, 1);
    add_pixel(255, 0, 254);
    add_pixel(255, 200, 10);
    add_pixel(200, 200, 5);
    add_pixel(200, 5, 200);
    add_pixel(5, 200, 200);
    add_pixel(10, 255, 128);
    add_pixel(30, 60, 255);
    add_pixel(255, 255, 0);
    add_pixel(0, 255, 255);
    add_pixel(255, 0, 255);
    add_pixel(1, 0, 0);
    add_pixel(255, 254, 254);
    add_pixel(0, 1, 255);
    add_pixel(170, 85, 85);
    wait_drained();

    add_random(300);
    wait_drained();

    // back to back with no idling on either side
    src_idle_pct = 0;
    snk_idle_pct = 0;
    add_random(200);
    wait_sent();

    // receiver holds off while the sender keeps offering items
    add_random(150);
    hold_req_cnt++;
    wait_sent();

    src_idle_pct = 30;
    snk_idle_pct = 30;
    add_random(150);
    wait_drained();
    repeat (3 * LATENCY) @(negedge clk);

    if (hsv_due_q.size() != 0) begin
      $error("%0d results never arrived", hsv_due_q.size());
      err_cnt += hsv_due_q.size();
    end
    $display("sent %0d pixels, checked %0d results (%0d grey, %0d red-max hue wraps)",
             pixels_sent, results_checked, grey_cnt, wrap_cnt);
    $display("phases: directed corners, random with idling, back to back, output hold-off");
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/rth_pkg.sv
rtl/core/rth_pix_if.sv
rtl/core/rth_hsv_if.sv
rtl/core/rth_front.sv
rtl/core/rth_div.sv
rtl/core/rgb_to_hsv_top.sv
bench/rgb_to_hsv_top_tb.sv
